// ===== design/shbi_pkg.sv =====
// ----------------------------------------------------------------------------
// shbi_pkg
// Shared widths and types for the sdbm string hash and bucket index block.
// ----------------------------------------------------------------------------
`default_nettype none

package shbi_pkg;

  localparam int HASH_W  = 64;
  localparam int TSIZE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int CNT_W   = $clog2(HASH_W + 1);
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [TSIZE_W-1:0] tsize;
  } job_t;

endpackage

`default_nettype wire

// ===== design/shbi_front.sv =====
// ----------------------------------------------------------------------------
// shbi_front
// Takes key bytes, runs the sdbm update and hands each finished key, with
// the table size in force at its terminator, to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module shbi_front import shbi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [CHAR_W-1:0]  key_char,
  input  wire logic               cfg_write,
  input  wire logic [TSIZE_W-1:0] cfg_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output job_t                    q_data
);

  logic [HASH_W-1:0]  hash;
  logic [HASH_W-1:0]  hash_next;
  logic [TSIZE_W-1:0] table_size;
  logic               accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  assign hash_next = HASH_W'(key_char) + (hash << 6) + (hash << 16) - hash;

  assign q_push       = accept && (key_char == '0);
  assign q_data.hash  = hash;
  assign q_data.tsize = table_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash       <= '0;
      table_size <= TSIZE_W'(1);
    end else begin
      if (cfg_write) begin
        table_size <= cfg_data;
      end
      if (accept) begin
        if (key_char == '0) begin
          hash <= '0;
        end else begin
          hash <= hash_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/shbi_queue.sv =====
// ----------------------------------------------------------------------------
// shbi_queue
// Short job queue between the hash front and the modulo back.
// ----------------------------------------------------------------------------
`default_nettype none

module shbi_queue import shbi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_data,
  output logic      empty
);

  job_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == Q_CW'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/shbi_back.sv =====
// ----------------------------------------------------------------------------
// shbi_back
// Restoring divider, one quotient bit per cycle, giving hash mod table size
// (zero for a table size of zero), followed by the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module shbi_back import shbi_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire job_t                q_data,
  output logic                     q_pop,
  output logic                     empty,
  input  wire logic                pop,
  output logic [63:0]              hash_value,
  output logic [TSIZE_W-1:0]       bucket_index
);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [HASH_W-1:0]  hash;
  logic [HASH_W-1:0]  dividend;
  logic [TSIZE_W-1:0] divisor;
  logic [TSIZE_W-1:0] rem;
  logic [TSIZE_W:0]   trial;
  logic [TSIZE_W:0]   diff;
  logic               out_valid;
  logic               done;
  logic               out_free;

  assign trial    = {rem, dividend[HASH_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign done     = busy && (cnt == '0);
  assign out_free = !out_valid || pop;
  assign q_pop    = !busy && !q_empty;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hash     <= q_data.hash;
      dividend <= q_data.hash;
      divisor  <= q_data.tsize;
      rem      <= '0;
    end else if (busy && cnt != '0) begin
      dividend <= dividend << 1;
      rem      <= (trial >= {1'b0, divisor}) ? diff[TSIZE_W-1:0] : trial[TSIZE_W-1:0];
    end
    if (done && out_free) begin
      hash_value   <= 64'(hash);
      bucket_index <= (divisor == '0) ? '0 : rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(HASH_W);
      end else if (busy && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else if (done && out_free) begin
        busy <= 1'b0;
      end
      if (done && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/string_hash_bucket_index.sv =====
// ----------------------------------------------------------------------------
// string_hash_bucket_index
// A terminator's job passes the queue, the divider and the result register.
// Throughput: one key byte per cycle while the queue is not full; the divider
// takes one key at a time, one remainder bit a cycle, overlapping the next key.
// Reset: synchronous, clears the running hash, queue and result valid flag; table size 1.
// ----------------------------------------------------------------------------
`default_nettype none

module string_hash_bucket_index import shbi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [CHAR_W-1:0]  key_char,
  input  wire logic               cfg_write,
  input  wire logic [TSIZE_W-1:0] cfg_data,
  output logic                    empty,
  input  wire logic               pop,
  output logic [63:0]             hash_value,
  output logic [TSIZE_W-1:0]      bucket_index
);

  job_t front_job;
  job_t back_job;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  shbi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .key_char  (key_char),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (front_job)
  );

  shbi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (front_job),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (back_job),
    .empty   (q_empty)
  );

  shbi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (back_job),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .hash_value   (hash_value),
    .bucket_index (bucket_index)
  );

endmodule

`default_nettype wire
